### sv/lss_pkg.sv
`default_nettype none

package lss_pkg;

  localparam int DepthDef     = 16;
  localparam int DataWidthDef = 32;

  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_SEARCH = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_BADPOS    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND  = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] value;
    logic [4:0]  position;
  } lss_in_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic [4:0]  found_at;
    logic [2:0]  status;
    logic [4:0]  count;
    logic        is_empty;
    logic        is_full;
  } lss_out_t;

endpackage

`default_nettype wire

### sv/lifo_stack_with_search.sv
`default_nettype none

// LIFO stack of DEPTH words held in a single-port-read synchronous memory, with
// positional read and linear search from the bottom. A transaction is taken when
// start is high and busy is low; each one gives exactly one result, shown for one
// cycle with out_valid high, and the receiver cannot stall it. Push and every
// failed operation give the result in the cycle after the transaction and keep
// busy low. Pop and valid read hold busy for one cycle while the memory is read;
// the result is registered from the memory's read data. A search walks the memory
// one entry per cycle through its single read port and holds busy until it stops
// at the first match or, on a miss, after all count entries (at most DEPTH).
module lifo_stack_with_search
  import lss_pkg::*;
#(
  parameter int DEPTH      = DepthDef,
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire lss_in_t  in_item,
  output logic          out_valid,
  output lss_out_t      out_item
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;
  localparam int DWX  = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic [1:0]            state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lss_out_t              out_r, out_nxt;

  logic                  we;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;

  logic                  accept;
  logic [DWX-1:0]        val_ext;
  logic [DATA_WIDTH-1:0] val_in;
  logic [DWX-1:0]        rd_ext;
  logic [CMPW-1:0]       pos_ext;
  logic [CMPW-1:0]       cnt_ext;
  logic [CMPW-1:0]       cnt_nxt_ext;
  logic [CW-1:0]         idx_p1;
  logic [CMPW-1:0]       idx_p1_ext;
  logic [AW-1:0]         pos_m1;

  assign accept      = start && !busy;
  assign val_ext     = DWX'(in_item.value);
  assign val_in      = val_ext[DATA_WIDTH-1:0];
  assign rd_ext      = DWX'(rd_data_r);
  assign pos_ext     = CMPW'(in_item.position);
  assign cnt_ext     = CMPW'(cnt_r);
  assign cnt_nxt_ext = CMPW'(cnt_nxt);
  assign idx_p1      = CW'(idx_r) + CW'(1);
  assign idx_p1_ext  = CMPW'(idx_p1);
  assign pos_m1      = AW'(pos_ext - CMPW'(1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    we            = 1'b0;
    wr_addr       = AW'(cnt_r);
    wr_data       = val_in;
    rd_en         = 1'b0;
    rd_addr       = '0;
    out_nxt.data_out = '0;
    out_nxt.found_at = '0;
    out_nxt.status   = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.mode)
            MODE_PUSH: begin
              out_valid_nxt = 1'b1;
              if (cnt_r == CW'(DEPTH)) begin
                out_nxt.status = ST_OVERFLOW;
              end else begin
                we      = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            MODE_POP: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = ST_UNDERFLOW;
              end else begin
                cnt_nxt   = cnt_r - CW'(1);
                rd_en     = 1'b1;
                rd_addr   = AW'(cnt_r - CW'(1));
                state_nxt = S_RD;
              end
            end
            MODE_READ: begin
              if (pos_ext == '0 || pos_ext > cnt_ext) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = ST_BADPOS;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = pos_m1;
                state_nxt = S_RD;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = ST_NOTFOUND;
              end else begin
                key_nxt   = val_in;
                idx_nxt   = '0;
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_SRCH;
              end
            end
          endcase
        end
      end
      S_RD: begin
        out_valid_nxt    = 1'b1;
        out_nxt.data_out = rd_ext[31:0];
        state_nxt        = S_IDLE;
      end
      S_SRCH: begin
        if (rd_data_r == key_r) begin
          out_valid_nxt    = 1'b1;
          out_nxt.found_at = idx_p1_ext[4:0];
          state_nxt        = S_IDLE;
        end else if (idx_p1 == cnt_r) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = ST_NOTFOUND;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt = AW'(idx_p1);
          rd_en   = 1'b1;
          rd_addr = AW'(idx_p1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_nxt.count    = cnt_nxt_ext[4:0];
    out_nxt.is_empty = (cnt_nxt == '0);
    out_nxt.is_full  = (cnt_nxt == CW'(DEPTH));
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire
